// ----- rtl/itr_pkg.sv -----
`default_nettype none
package itr_pkg;

  localparam int unsigned BufferDepthDefault = 16;
  localparam int unsigned TimeWidth = 62;
  localparam int unsigned PeriodWidth = 30;
  localparam int unsigned DepthCfgWidth = 5;
  localparam int unsigned CfgDataWidth = 30;
  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [PeriodWidth-1:0] PeriodReset = 30'd2000000;
  localparam logic [DepthCfgWidth-1:0] DepthReset = 5'd10;
  localparam logic [CfgIndexWidth-1:0] CfgPeriod = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CfgDepth = 1'b1;
  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic cmd;
    logic [61:0] sample_time;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [61:0] out_time;
    logic signed [15:0] out_quat_w;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;
    logic signed [15:0] out_rate_x;
    logic signed [15:0] out_rate_y;
    logic signed [15:0] out_rate_z;
    logic signed [15:0] out_accel_x;
    logic signed [15:0] out_accel_y;
    logic signed [15:0] out_accel_z;
  } out_item_t;

  // One buffered sample: time plus ten 16-bit channels.
  typedef struct packed {
    logic [61:0] stamp;
    logic [9:0][15:0] chan;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/imu_timestamp_resampler.sv -----
`default_nettype none
// IMU resampler: samples (cmd 0) are kept in a time-sorted register buffer of
// BUFFER_DEPTH entries; a tick (cmd 1) emits at most one linearly interpolated
// sample at the next output time with a renormalized quaternion. One request
// is handled at a time. A sample goes through a serial position search, then
// one shift pass (skipped when it is older than every entry of a full buffer),
// then drops surplus entries one per pass. A tick goes through a serial bracket
// search, a bit-serial alpha division, the lerps on one shared multiplier, the
// squared norm, a bit-serial square root, four bit-serial component divisions
// and the output load. A result waiting at the output holds back only the tick
// behind it. There is no clearing pass after reset.
module imu_timestamp_resampler #(
  parameter int unsigned BUFFER_DEPTH = itr_pkg::BufferDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire itr_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output itr_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [itr_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [itr_pkg::CfgDataWidth-1:0] cfg_data
);
  import itr_pkg::*;

  localparam int unsigned IdxW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_SHIFT, ST_DROP, ST_START,
    ST_SCAN, ST_ALPHA, ST_LERP, ST_NORM, ST_SQRT, ST_DIV, ST_OUT
  } state_t;

  state_t state;
  entry_t buf_q [BUFFER_DEPTH];
  entry_t newcomer;
  logic [PeriodWidth-1:0] period;
  logic [DepthCfgWidth-1:0] depth_cfg;
  logic [CntW-1:0] fill_count;
  logic [TimeWidth-1:0] next_emit_time, newest_time;
  logic started;
  logic [CntW-1:0] ptr;
  logic [CntW-1:0] pos;
  // Division / alpha.
  logic [TimeWidth:0] rem;
  logic [TimeWidth-1:0] gap;
  logic [16:0] alpha;
  logic [4:0] bitcnt;
  logic [3:0] lane;
  logic signed [15:0] res [10];
  logic [33:0] n2;
  // Square root of n2 << 16 (50 bits): restoring, two bits a step.
  logic [49:0] sq_x;
  logic [25:0] root;
  logic [27:0] sq_rem;
  logic [5:0] sq_cnt;
  // Component division.
  logic [38:0] dv_num;
  logic [26:0] dv_rem;
  logic [38:0] dv_q;
  logic [5:0] dv_cnt;

  logic [CntW-1:0] lim;
  always_comb begin
    if (depth_cfg == '0) lim = CntW'(1);
    else if (32'(depth_cfg) > BUFFER_DEPTH) lim = CntW'(BUFFER_DEPTH);
    else lim = CntW'(depth_cfg);
  end

  assign in_ready = (state == ST_IDLE);

  logic [IdxW-1:0] pi, pi1;
  assign pi = ptr[IdxW-1:0];
  assign pi1 = IdxW'(ptr + CntW'(1));

  // Lerp: a*65536 + alpha*(b-a), rounded half up. Lane 0 is quat_w, which
  // sits in the top slice of the packed channel array.
  logic signed [15:0] la, lb;
  logic signed [17:0] ldiff;
  logic signed [35:0] lprod;
  logic signed [36:0] lsum;
  always_comb begin
    la = buf_q[pi].chan[4'd9 - lane];
    lb = buf_q[pi1].chan[4'd9 - lane];
    ldiff = 18'(lb) - 18'(la);
    lprod = $signed({1'b0, alpha}) * ldiff;
    lsum = 37'(lprod) + (37'(la) <<< 16) + 37'sd32768;
  end
  logic signed [31:0] sqprod;
  assign sqprod = res[lane] * res[lane];

  logic [27:0] sq_trial;
  assign sq_trial = {sq_rem[25:0], sq_x[49:48]} - {root, 2'b01};
  logic [26:0] dv_shift;
  assign dv_shift = {dv_rem[25:0], dv_num[38]};

  logic [15:0] cabs;
  assign cabs = res[lane][15] ? 16'(-res[lane]) : res[lane];
  logic [TimeWidth:0] a_shift;
  assign a_shift = {rem[TimeWidth-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      fill_count <= '0;
      next_emit_time <= '0;
      newest_time <= '0;
      started <= 1'b0;
      period <= PeriodReset;
      depth_cfg <= DepthReset;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgPeriod: period <= cfg_data[PeriodWidth-1:0];
          CfgDepth: depth_cfg <= cfg_data[DepthCfgWidth-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            ptr <= '0;
            if (in_data.cmd == CmdSample) begin
              newcomer.stamp <= in_data.sample_time;
              newcomer.chan <= {in_data.quat_w, in_data.quat_x, in_data.quat_y,
                in_data.quat_z, in_data.rate_x, in_data.rate_y, in_data.rate_z,
                in_data.accel_x, in_data.accel_y, in_data.accel_z};
              state <= ST_FIND;
            end else if (started && fill_count >= CntW'(2)
                         && next_emit_time < newest_time) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_FIND: begin
          if (ptr < fill_count && buf_q[pi].stamp <= newcomer.stamp) begin
            ptr <= ptr + CntW'(1);
          end else begin
            if (newcomer.stamp > newest_time) newest_time <= newcomer.stamp;
            if (fill_count == CntW'(BUFFER_DEPTH)) begin
              // A full buffer always loses its oldest entry, so drop it first
              // to make room. A newcomer older than every entry is that one.
              if (ptr == '0) begin
                state <= ST_DROP;
              end else begin
                for (int i = 0; i < BUFFER_DEPTH - 1; i++) buf_q[i] <= buf_q[i + 1];
                fill_count <= fill_count - CntW'(1);
                pos <= ptr - CntW'(1);
                ptr <= fill_count - CntW'(1);
                state <= ST_SHIFT;
              end
            end else begin
              pos <= ptr;
              ptr <= fill_count;
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          // Moves entries up one at a time from the top; the newcomer lands at
          // pos.
          if (ptr > pos) begin
            if (32'(ptr) < BUFFER_DEPTH) buf_q[pi] <= buf_q[IdxW'(ptr - CntW'(1))];
            ptr <= ptr - CntW'(1);
          end else begin
            if (32'(pos) < BUFFER_DEPTH) buf_q[pos[IdxW-1:0]] <= newcomer;
            fill_count <= fill_count + CntW'(1);
            ptr <= '0;
            state <= ST_DROP;
          end
        end
        ST_DROP: begin
          // Drop the oldest entry one per pass until the count fits.
          if (fill_count > lim) begin
            for (int i = 0; i < BUFFER_DEPTH - 1; i++) buf_q[i] <= buf_q[i + 1];
            fill_count <= fill_count - CntW'(1);
          end else begin
            state <= ST_START;
          end
        end
        ST_START: begin
          if (!started) begin
            next_emit_time <= buf_q[0].stamp + TimeWidth'(period);
            started <= 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (ptr + CntW'(1) >= fill_count) begin
            state <= ST_IDLE;
          end else if (buf_q[pi].stamp <= next_emit_time
                       && next_emit_time <= buf_q[pi1].stamp
                       && buf_q[pi1].stamp > buf_q[pi].stamp) begin
            gap <= buf_q[pi1].stamp - buf_q[pi].stamp;
            rem <= {1'b0, next_emit_time - buf_q[pi].stamp};
            alpha <= '0;
            bitcnt <= '0;
            state <= ST_ALPHA;
          end else begin
            ptr <= ptr + CntW'(1);
          end
        end
        ST_ALPHA: begin
          if (bitcnt == 5'd0 && rem[TimeWidth-1:0] >= gap) begin
            alpha <= 17'd65536;
            lane <= '0;
            state <= ST_LERP;
          end else if (bitcnt == 5'd16) begin
            lane <= '0;
            state <= ST_LERP;
          end else begin
            if (a_shift >= {1'b0, gap}) begin
              rem <= a_shift - {1'b0, gap};
              alpha <= {alpha[15:0], 1'b1};
            end else begin
              rem <= a_shift;
              alpha <= {alpha[15:0], 1'b0};
            end
            bitcnt <= bitcnt + 5'd1;
          end
        end
        ST_LERP: begin
          res[lane] <= lsum[31:16];
          if (lane == 4'd9) begin
            lane <= '0;
            n2 <= '0;
            state <= ST_NORM;
          end else begin
            lane <= lane + 4'd1;
          end
        end
        ST_NORM: begin
          n2 <= n2 + 34'($unsigned(sqprod));
          if (lane == 4'd3) begin
            sq_x <= {n2 + 34'($unsigned(sqprod)), 16'd0};
            root <= '0;
            sq_rem <= '0;
            sq_cnt <= '0;
            lane <= '0;
            if (n2 + 34'($unsigned(sqprod)) == '0) state <= ST_OUT;
            else state <= ST_SQRT;
          end else begin
            lane <= lane + 4'd1;
          end
        end
        ST_SQRT: begin
          if (sq_cnt == 6'd25) begin
            dv_num <= {1'b0, cabs, 22'd0};
            dv_rem <= '0;
            dv_q <= '0;
            dv_cnt <= '0;
            state <= ST_DIV;
          end else begin
            if (!sq_trial[27]) begin
              sq_rem <= sq_trial;
              root <= {root[24:0], 1'b1};
            end else begin
              sq_rem <= {sq_rem[25:0], sq_x[49:48]};
              root <= {root[24:0], 1'b0};
            end
            sq_x <= {sq_x[47:0], 2'b00};
            sq_cnt <= sq_cnt + 6'd1;
          end
        end
        ST_DIV: begin
          // Bit-serial (|c| << 22 + root/2) / root; the rounding term is
          // handled by comparing twice the remainder with root at the end.
          if (dv_cnt == 6'd39) begin
            if (res[lane][15]) begin
              if (dv_q + 39'({dv_rem, 1'b0} >= 28'(root)) > 39'd32768)
                res[lane] <= -16'sd32768;
              else
                res[lane] <= 16'(-(dv_q + 39'({dv_rem, 1'b0} >= 28'(root))));
            end else begin
              if (dv_q + 39'({dv_rem, 1'b0} >= 28'(root)) > 39'd32767)
                res[lane] <= 16'sd32767;
              else
                res[lane] <= 16'(dv_q + 39'({dv_rem, 1'b0} >= 28'(root)));
            end
            dv_cnt <= '0;
            dv_q <= '0;
            dv_rem <= '0;
            if (lane == 4'd3) begin
              state <= ST_OUT;
            end else begin
              dv_num <= {1'b0, (res[lane + 4'd1][15]
                ? 16'(-res[lane + 4'd1]) : res[lane + 4'd1]), 22'd0};
              lane <= lane + 4'd1;
            end
          end else begin
            if (dv_shift >= 27'(root)) begin
              dv_rem <= dv_shift - 27'(root);
              dv_q <= {dv_q[37:0], 1'b1};
            end else begin
              dv_rem <= dv_shift;
              dv_q <= {dv_q[37:0], 1'b0};
            end
            dv_num <= {dv_num[37:0], 1'b0};
            dv_cnt <= dv_cnt + 6'd1;
          end
        end
        ST_OUT: begin
          // The tick waits here while the previous result is still held.
          if (!out_valid) begin
            out_data <= {next_emit_time, res[0], res[1], res[2], res[3], res[4],
              res[5], res[6], res[7], res[8], res[9]};
            out_valid <= 1'b1;
            next_emit_time <= next_emit_time + TimeWidth'(period);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= BUFFER_DEPTH) else $error("fill count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_emit_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_valid) |=> out_valid) else $error("result lost");
`endif

endmodule
`default_nettype wire
